/* hw/rtl/pchc_pkg.sv */
// ----------------------------------------------------------------------------
// Point cloud hazard classifier package
// Shared widths, constants, command codes and controller/datapath structs.
// ----------------------------------------------------------------------------
package pchc_pkg;

   // Configuration port.
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 48;

   localparam logic [CSR_INDEX_W-1:0] REG_PLANE_A     = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_PLANE_B     = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_PLANE_C     = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_PLANE_D     = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_VERTICAL    = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_OBS_LOW     = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] REG_OBS_HIGH    = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] REG_GROUND_INL  = 3'd7;

   // Register and field widths.
   localparam int COEF_W   = 24;
   localparam int OFFSET_W = 48;
   localparam int THRESH_W = 20;
   localparam int LEVEL_W  = 3;
   localparam int TOTAL_W  = 20;
   localparam int RSP_DATA_W = 48;

   // Datapath widths, sized for the widest supported coordinate.
   localparam int COORD_MAX = 24;
   localparam int MUL_W     = 28;
   localparam int PROD_W    = 2 * MUL_W;
   localparam int DOT_W     = 50;
   localparam int SUM_W     = DOT_W + 1;
   localparam int HALF_W    = 26;
   localparam int MAG_W     = 2 * HALF_W;
   localparam int ACC_W     = 50;
   localparam int RHS_W     = 62;
   localparam int SQ_W      = 104;

   // Geometry and decision constants.
   localparam int NEAR_LIMIT_SQ   = 740 * 740;
   localparam int PLANE_MARGIN_MM = 60;
   localparam int HOLE_Y_LIMIT    = 1500;
   localparam int HOLE_LOW        = 25000;
   localparam int HOLE_HIGH       = 40000;
   localparam int GROUND_MIN      = 50000;
   localparam int SIDE_WINDOW     = 300;
   localparam int FAR_WINDOW      = 500;

   // Configuration reset values.
   localparam int RST_PLANE_C  = 1;
   localparam int RST_OBS_LOW  = 10000;
   localparam int RST_OBS_HIGH = 40000;

   // Parameter defaults.
   localparam int DEF_COUNT_WIDTH = 20;
   localparam int DEF_COORD_WIDTH = 16;

   // Hazard levels.
   localparam logic [LEVEL_W-1:0] LVL_SAFE           = 3'd0;
   localparam logic [LEVEL_W-1:0] LVL_NO_GROUND      = 3'd1;
   localparam logic [LEVEL_W-1:0] LVL_POSSIBLE_OBST  = 3'd2;
   localparam logic [LEVEL_W-1:0] LVL_CLOSE_OBST     = 3'd3;
   localparam logic [LEVEL_W-1:0] LVL_POSSIBLE_HOLE  = 3'd4;
   localparam logic [LEVEL_W-1:0] LVL_CLOSE_HOLE     = 3'd5;

   // Multiplier operations issued by the controller.
   localparam int MUL_OP_W = 4;
   localparam logic [MUL_OP_W-1:0] MUL_NONE = 4'd0;
   localparam logic [MUL_OP_W-1:0] MUL_AX   = 4'd1;
   localparam logic [MUL_OP_W-1:0] MUL_BY   = 4'd2;
   localparam logic [MUL_OP_W-1:0] MUL_CZ   = 4'd3;
   localparam logic [MUL_OP_W-1:0] MUL_AA   = 4'd4;
   localparam logic [MUL_OP_W-1:0] MUL_BB   = 4'd5;
   localparam logic [MUL_OP_W-1:0] MUL_CC   = 4'd6;
   localparam logic [MUL_OP_W-1:0] MUL_XX   = 4'd7;
   localparam logic [MUL_OP_W-1:0] MUL_YY   = 4'd8;
   localparam logic [MUL_OP_W-1:0] MUL_ZZ   = 4'd9;
   localparam logic [MUL_OP_W-1:0] MUL_LL   = 4'd10;
   localparam logic [MUL_OP_W-1:0] MUL_HL   = 4'd11;
   localparam logic [MUL_OP_W-1:0] MUL_HH   = 4'd12;

   typedef struct packed {
      logic                load;
      logic [MUL_OP_W-1:0] mul_op;
      logic                abs_en;
      logic                rhs_en;
      logic                decide_en;
      logic                emit_en;
   } pchc_cmd_type;

   typedef struct packed {
      logic last;
   } pchc_status_type;

endpackage

/* hw/rtl/pchc_datapath.sv */
// ----------------------------------------------------------------------------
// Point cloud hazard classifier datapath
// Configuration registers, shared multiplier, accumulators, frame counters
// and the result register.
// ----------------------------------------------------------------------------
module pchc_datapath
   import pchc_pkg::*;
#(
   parameter int COUNT_WIDTH = DEF_COUNT_WIDTH,
   parameter int COORD_WIDTH = DEF_COORD_WIDTH
) (
   input  logic                          clock,
   input  logic                          reset,
   input  pchc_cmd_type                  cmd,
   output pchc_status_type               status,
   input  logic                          csr_we,
   input  logic [CSR_INDEX_W-1:0]        csr_index,
   input  logic [CSR_DATA_W-1:0]         csr_wdata,
   input  logic signed [COORD_WIDTH-1:0] point_x,
   input  logic signed [COORD_WIDTH-1:0] point_y,
   input  logic signed [COORD_WIDTH-1:0] point_z,
   input  logic                          frame_end,
   output logic [LEVEL_W-1:0]            hazard_level,
   output logic [TOTAL_W-1:0]            obstacle_total,
   output logic [TOTAL_W-1:0]            hole_total
);

   localparam int CMP_W = (COUNT_WIDTH > THRESH_W) ? COUNT_WIDTH : THRESH_W;

   localparam logic [2:0] DST_NONE = 3'd0;
   localparam logic [2:0] DST_DOT  = 3'd1;
   localparam logic [2:0] DST_NORM = 3'd2;
   localparam logic [2:0] DST_RAD  = 3'd3;
   localparam logic [2:0] DST_SQ0  = 3'd4;
   localparam logic [2:0] DST_SQ1  = 3'd5;
   localparam logic [2:0] DST_SQ2  = 3'd6;

   localparam logic signed [COORD_MAX-1:0] SIDE_POS = COORD_MAX'(SIDE_WINDOW);
   localparam logic signed [COORD_MAX-1:0] SIDE_NEG = -SIDE_POS;
   localparam logic signed [COORD_MAX-1:0] FAR_POS  = COORD_MAX'(FAR_WINDOW);
   localparam logic signed [COORD_MAX-1:0] FAR_NEG  = -FAR_POS;
   localparam logic signed [COORD_MAX-1:0] Y_LIMIT  = COORD_MAX'(HOLE_Y_LIMIT);
   localparam logic signed [DOT_W-1:0]     MARGIN_POS = DOT_W'(PLANE_MARGIN_MM);
   localparam logic signed [DOT_W-1:0]     MARGIN_NEG = -MARGIN_POS;
   localparam logic [COUNT_WIDTH-1:0]      COUNT_TOP = '1;

   // Configuration registers.
   logic signed [COEF_W-1:0]   a_ff, b_ff, c_ff;
   logic signed [OFFSET_W-1:0] d_ff;
   logic                       vert_ff;
   logic [THRESH_W-1:0]        obs_lo_ff, obs_hi_ff, inliers_ff;

   // Current point.
   logic signed [COORD_MAX-1:0] x_ff, y_ff, z_ff;
   logic                        last_ff;

   // Multiplier and accumulators.
   logic signed [MUL_W-1:0]  op_a, op_b;
   logic [2:0]               dest_in;
   logic signed [PROD_W-1:0] product_in, product_ff;
   logic [2:0]               dest_ff;
   logic signed [DOT_W-1:0]  dot_ff;
   logic signed [SUM_W-1:0]  sum_in;
   logic [MAG_W-1:0]         mag_ff;
   logic [ACC_W-1:0]         norm_ff, rad_ff;
   logic [RHS_W-1:0]         rhs_ff;
   logic [SQ_W-1:0]          sq_ff, prod_wide;

   // Frame counters and result.
   logic [COUNT_WIDTH-1:0] obst_count_ff, hole_count_ff;
   logic [LEVEL_W-1:0]     level_in, level_ff;
   logic [TOTAL_W-1:0]     obst_total_ff, hole_total_ff;
   logic                   skip, flip, off_plane, near, below;
   logic [CMP_W-1:0]       obst_cmp, hole_cmp;

   assign status.last = last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_ff       <= '0;
         b_ff       <= '0;
         c_ff       <= COEF_W'(RST_PLANE_C);
         d_ff       <= '0;
         vert_ff    <= 1'b0;
         obs_lo_ff  <= THRESH_W'(RST_OBS_LOW);
         obs_hi_ff  <= THRESH_W'(RST_OBS_HIGH);
         inliers_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_PLANE_A:    a_ff       <= csr_wdata[COEF_W-1:0];
            REG_PLANE_B:    b_ff       <= csr_wdata[COEF_W-1:0];
            REG_PLANE_C:    c_ff       <= csr_wdata[COEF_W-1:0];
            REG_PLANE_D:    d_ff       <= csr_wdata[OFFSET_W-1:0];
            REG_VERTICAL:   vert_ff    <= csr_wdata[0];
            REG_OBS_LOW:    obs_lo_ff  <= csr_wdata[THRESH_W-1:0];
            REG_OBS_HIGH:   obs_hi_ff  <= csr_wdata[THRESH_W-1:0];
            REG_GROUND_INL: inliers_ff <= csr_wdata[THRESH_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      op_a    = '0;
      op_b    = '0;
      dest_in = DST_NONE;
      unique case (cmd.mul_op)
         MUL_NONE: ;
         MUL_AX: begin
            op_a = MUL_W'(a_ff); op_b = MUL_W'(x_ff); dest_in = DST_DOT;
         end
         MUL_BY: begin
            op_a = MUL_W'(b_ff); op_b = MUL_W'(y_ff); dest_in = DST_DOT;
         end
         MUL_CZ: begin
            op_a = MUL_W'(c_ff); op_b = MUL_W'(z_ff); dest_in = DST_DOT;
         end
         MUL_AA: begin
            op_a = MUL_W'(a_ff); op_b = MUL_W'(a_ff); dest_in = DST_NORM;
         end
         MUL_BB: begin
            op_a = MUL_W'(b_ff); op_b = MUL_W'(b_ff); dest_in = DST_NORM;
         end
         MUL_CC: begin
            op_a = MUL_W'(c_ff); op_b = MUL_W'(c_ff); dest_in = DST_NORM;
         end
         MUL_XX: begin
            op_a = MUL_W'(x_ff); op_b = MUL_W'(x_ff); dest_in = DST_RAD;
         end
         MUL_YY: begin
            op_a = MUL_W'(y_ff); op_b = MUL_W'(y_ff); dest_in = DST_RAD;
         end
         MUL_ZZ: begin
            op_a = MUL_W'(z_ff); op_b = MUL_W'(z_ff); dest_in = DST_RAD;
         end
         MUL_LL: begin
            op_a    = MUL_W'(mag_ff[HALF_W-1:0]);
            op_b    = MUL_W'(mag_ff[HALF_W-1:0]);
            dest_in = DST_SQ0;
         end
         MUL_HL: begin
            op_a    = MUL_W'(mag_ff[MAG_W-1:HALF_W]);
            op_b    = MUL_W'(mag_ff[HALF_W-1:0]);
            dest_in = DST_SQ1;
         end
         MUL_HH: begin
            op_a    = MUL_W'(mag_ff[MAG_W-1:HALF_W]);
            op_b    = MUL_W'(mag_ff[MAG_W-1:HALF_W]);
            dest_in = DST_SQ2;
         end
         default: ;
      endcase
   end

   assign product_in = op_a * op_b;
   assign prod_wide  = SQ_W'(unsigned'(product_ff));
   assign sum_in     = SUM_W'(dot_ff) + SUM_W'(d_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         dest_ff <= DST_NONE;
      end else begin
         dest_ff <= dest_in;
      end
      product_ff <= product_in;
   end

   // The cross term of the square carries a factor of two, hence one extra shift.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         x_ff    <= COORD_MAX'(point_x);
         y_ff    <= COORD_MAX'(point_y);
         z_ff    <= COORD_MAX'(point_z);
         last_ff <= frame_end;
         dot_ff  <= '0;
         norm_ff <= '0;
         rad_ff  <= '0;
         sq_ff   <= '0;
      end else begin
         case (dest_ff)
            DST_DOT:  dot_ff  <= dot_ff + DOT_W'(product_ff);
            DST_NORM: norm_ff <= norm_ff + ACC_W'(unsigned'(product_ff));
            DST_RAD:  rad_ff  <= rad_ff + ACC_W'(unsigned'(product_ff));
            DST_SQ0:  sq_ff   <= sq_ff + prod_wide;
            DST_SQ1:  sq_ff   <= sq_ff + (prod_wide << (HALF_W + 1));
            DST_SQ2:  sq_ff   <= sq_ff + (prod_wide << (2 * HALF_W));
            default: ;
         endcase
      end
      if (cmd.abs_en) begin
         mag_ff <= (sum_in < 0) ? MAG_W'(-sum_in) : MAG_W'(sum_in);
      end
      // Margin squared is 3600 = 4096 - 512 + 16.
      if (cmd.rhs_en) begin
         rhs_ff <= (RHS_W'(norm_ff) << 12) - (RHS_W'(norm_ff) << 9)
                 + (RHS_W'(norm_ff) << 4);
      end
   end

   always_comb begin
      if (vert_ff) begin
         skip = (x_ff < FAR_NEG) || (z_ff < SIDE_NEG) || (z_ff > SIDE_POS);
         flip = a_ff > 0;
      end else begin
         skip = (x_ff < SIDE_NEG) || (x_ff > SIDE_POS) || (z_ff > FAR_POS);
         flip = c_ff < 0;
      end
      off_plane = !skip && (sq_ff > SQ_W'(rhs_ff));
      near      = rad_ff < ACC_W'(NEAR_LIMIT_SQ);
      below     = (flip ? (dot_ff < MARGIN_NEG) : (dot_ff > MARGIN_POS))
                  && (y_ff < Y_LIMIT);
   end

   always_comb begin
      obst_cmp = CMP_W'(obst_count_ff);
      hole_cmp = CMP_W'(hole_count_ff);
      if (inliers_ff <= THRESH_W'(GROUND_MIN)) begin
         level_in = LVL_NO_GROUND;
      end else if (obst_cmp >= CMP_W'(obs_hi_ff)) begin
         level_in = LVL_CLOSE_OBST;
      end else if (obst_cmp >= CMP_W'(obs_lo_ff)) begin
         level_in = LVL_POSSIBLE_OBST;
      end else if (hole_cmp >= CMP_W'(HOLE_HIGH)) begin
         level_in = LVL_CLOSE_HOLE;
      end else if (hole_cmp > CMP_W'(HOLE_LOW)) begin
         level_in = LVL_POSSIBLE_HOLE;
      end else begin
         level_in = LVL_SAFE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         obst_count_ff <= '0;
         hole_count_ff <= '0;
      end else if (cmd.emit_en) begin
         obst_count_ff <= '0;
         hole_count_ff <= '0;
      end else if (cmd.decide_en && off_plane) begin
         if (near && (obst_count_ff != COUNT_TOP)) begin
            obst_count_ff <= obst_count_ff + 1'b1;
         end
         if (below && (hole_count_ff != COUNT_TOP)) begin
            hole_count_ff <= hole_count_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit_en) begin
         level_ff      <= level_in;
         obst_total_ff <= TOTAL_W'(obst_count_ff);
         hole_total_ff <= TOTAL_W'(hole_count_ff);
      end
   end

   assign hazard_level   = level_ff;
   assign obstacle_total = obst_total_ff;
   assign hole_total     = hole_total_ff;

endmodule

/* hw/rtl/pchc_controller.sv */
// ----------------------------------------------------------------------------
// Point cloud hazard classifier controller
// Sequences the per-point multiply schedule and owns both handshakes.
// ----------------------------------------------------------------------------
module pchc_controller
   import pchc_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_tvalid,
   output logic            req_tready,
   output logic            rsp_tvalid,
   input  logic            rsp_tready,
   output pchc_cmd_type    cmd,
   input  pchc_status_type status
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_RUN  = 1'b1;

   localparam logic [3:0] STEP_ABS    = 4'd4;
   localparam logic [3:0] STEP_RHS    = 4'd12;
   localparam logic [3:0] STEP_DECIDE = 4'd13;
   localparam logic [3:0] STEP_EMIT   = 4'd14;

   logic       state_ff, state_in;
   logic [3:0] step_ff, step_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       rsp_busy, stall;

   assign rsp_busy   = rsp_valid_ff && !rsp_tready;
   assign stall      = status.last && rsp_busy;
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      cmd        = '0;
      cmd.mul_op = MUL_NONE;
      cmd.load   = req_tvalid && (state_ff == ST_IDLE);
      if (state_ff == ST_RUN) begin
         unique case (step_ff)
            4'd0:  cmd.mul_op = MUL_AX;
            4'd1:  cmd.mul_op = MUL_BY;
            4'd2:  cmd.mul_op = MUL_CZ;
            4'd3:  cmd.mul_op = MUL_AA;
            STEP_ABS: begin
               cmd.mul_op = MUL_BB;
               cmd.abs_en = 1'b1;
            end
            4'd5:  cmd.mul_op = MUL_LL;
            4'd6:  cmd.mul_op = MUL_HL;
            4'd7:  cmd.mul_op = MUL_HH;
            4'd8:  cmd.mul_op = MUL_CC;
            4'd9:  cmd.mul_op = MUL_XX;
            4'd10: cmd.mul_op = MUL_YY;
            4'd11: cmd.mul_op = MUL_ZZ;
            STEP_RHS:    cmd.rhs_en    = 1'b1;
            STEP_DECIDE: cmd.decide_en = 1'b1;
            STEP_EMIT:   cmd.emit_en   = status.last && !rsp_busy;
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = ST_RUN;
               step_in  = '0;
            end
         end
         ST_RUN: begin
            if (step_ff == STEP_EMIT) begin
               if (!stall) begin
                  state_in = ST_IDLE;
                  if (status.last) begin
                     rsp_valid_in = 1'b1;
                  end
               end
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

/* hw/rtl/point_cloud_hazard_classifier.sv */
// ----------------------------------------------------------------------------
// Point cloud hazard classifier
// Counts near off-plane points and below-plane points over a frame against a
// configured ground plane and reports a hazard level at each frame end.
// ----------------------------------------------------------------------------
// Each point is accepted in the idle state and then runs through fifteen steps
// before the next beat is taken: a single shared 28 x 28 multiplier forms the
// twelve products the point needs (plane dot product, coefficient norm, point
// radius and the square of the plane distance in partial products), followed by
// the threshold product, the counter update and, on the last point of a frame,
// the result. A result beat waits in an output register while the next point is
// accepted; a frame end stalls only if the previous result has not been taken
// yet. Configuration must be written only while the block is idle, which the
// block itself does not enforce; it takes effect on the next point.
// ----------------------------------------------------------------------------
module point_cloud_hazard_classifier
   import pchc_pkg::*;
#(
   parameter int COUNT_WIDTH = DEF_COUNT_WIDTH,
   parameter int COORD_WIDTH = DEF_COORD_WIDTH
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   // point_x, point_y, point_z
   input  logic [((3*COORD_WIDTH+7)/8)*8-1:0] req_tdata,
   // frame_end
   input  logic                    req_tlast,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   // hazard_level, obstacle_total, hole_total
   output logic [RSP_DATA_W-1:0]   rsp_tdata,
   input  logic                    csr_we,
   input  logic [CSR_INDEX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0]   csr_wdata
);

   pchc_cmd_type          cmd;
   pchc_status_type       status;
   logic [LEVEL_W-1:0]    hazard_level;
   logic [TOTAL_W-1:0]    obstacle_total, hole_total;

   pchc_controller u_controller (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .status     (status)
   );

   pchc_datapath #(
      .COUNT_WIDTH (COUNT_WIDTH),
      .COORD_WIDTH (COORD_WIDTH)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .point_x        (req_tdata[COORD_WIDTH-1:0]),
      .point_y        (req_tdata[2*COORD_WIDTH-1:COORD_WIDTH]),
      .point_z        (req_tdata[3*COORD_WIDTH-1:2*COORD_WIDTH]),
      .frame_end      (req_tlast),
      .hazard_level   (hazard_level),
      .obstacle_total (obstacle_total),
      .hole_total     (hole_total)
   );

   assign rsp_tdata = RSP_DATA_W'({hole_total, obstacle_total, hazard_level});

endmodule

/* tb/hazard_report_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Hazard report checker
// Watches the point, result and register ports of the hazard classifier. It
// keeps its own copy of the plane registers and the two frame counters, works
// out the report each frame end should produce, and compares every result beat
// field by field with the oldest outstanding report.
// ----------------------------------------------------------------------------
module hazard_report_checker
   import pchc_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   input  logic                   req_tready,
   // point_x, point_y, point_z
   input  logic [47:0]            req_tdata,
   // frame_end
   input  logic                   req_tlast,
   input  logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // hazard_level, obstacle_total, hole_total
   input  logic [RSP_DATA_W-1:0]  rsp_tdata,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   output int                     fail_count,
   output int                     expected_left,
   output int                     points_seen,
   output int                     reports_seen,
   output logic [7:0]             levels_seen
);

   typedef struct packed {
      logic [LEVEL_W-1:0] level;
      logic [TOTAL_W-1:0] obstacles;
      logic [TOTAL_W-1:0] holes;
   } hazard_report_type;

   hazard_report_type pending_reports[$];

   logic signed [COEF_W-1:0]   plane_a, plane_b, plane_c;
   logic signed [OFFSET_W-1:0] plane_d;
   logic                       vertical;
   logic [THRESH_W-1:0]        obs_low, obs_high, ground_inliers;
   logic [TOTAL_W-1:0]         obstacle_cnt, hole_cnt;

   int         mismatches;
   int         point_total;
   int         report_total;
   logic [7:0] level_mask;

   task automatic report_mismatch(input string what, input longint got, input longint want);
      mismatches++;
      $display("%0t mismatch in report %0d: %s got %0d expected %0d",
               $time, report_total, what, got, want);
   endtask

   task automatic store_reg(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      case (idx)
         REG_PLANE_A:    plane_a = value[COEF_W-1:0];
         REG_PLANE_B:    plane_b = value[COEF_W-1:0];
         REG_PLANE_C:    plane_c = value[COEF_W-1:0];
         REG_PLANE_D:    plane_d = value[OFFSET_W-1:0];
         REG_VERTICAL:   vertical = value[0];
         REG_OBS_LOW:    obs_low = value[THRESH_W-1:0];
         REG_OBS_HIGH:   obs_high = value[THRESH_W-1:0];
         REG_GROUND_INL: ground_inliers = value[THRESH_W-1:0];
         default: ;
      endcase
   endtask

   task automatic tally_point(input logic [47:0] beat, input logic last);
      logic signed [15:0] sx, sy, sz;
      longint             px, py, pz, dot, plane_dist, norm2, rhs, r2;
      logic [127:0]       mag, mag_sq;
      logic               skip, flip;
      hazard_report_type  rep;
      sx = beat[15:0];
      sy = beat[31:16];
      sz = beat[47:32];
      px = longint'(sx);
      py = longint'(sy);
      pz = longint'(sz);
      if (vertical) begin
         skip = (px < -FAR_WINDOW) || (pz < -SIDE_WINDOW) || (pz > SIDE_WINDOW);
      end else begin
         skip = (px < -SIDE_WINDOW) || (px > SIDE_WINDOW) || (pz > FAR_WINDOW);
      end
      if (!skip) begin
         dot = longint'(plane_a) * px + longint'(plane_b) * py + longint'(plane_c) * pz;
         plane_dist = dot + longint'(plane_d);
         mag = 128'((plane_dist < 0) ? -plane_dist : plane_dist);
         mag_sq = mag * mag;
         norm2 = longint'(plane_a) * longint'(plane_a) + longint'(plane_b) * longint'(plane_b)
               + longint'(plane_c) * longint'(plane_c);
         rhs = norm2 * longint'(PLANE_MARGIN_MM * PLANE_MARGIN_MM);
         flip = vertical ? (plane_a > 0) : (plane_c < 0);
         if (mag_sq > 128'(rhs)) begin
            r2 = px * px + py * py + pz * pz;
            if (flip) begin
               dot = -dot;
            end
            if (r2 < longint'(NEAR_LIMIT_SQ) && obstacle_cnt != '1) begin
               obstacle_cnt++;
            end
            if (dot > longint'(PLANE_MARGIN_MM) && py < longint'(HOLE_Y_LIMIT)
                && hole_cnt != '1) begin
               hole_cnt++;
            end
         end
      end
      if (last) begin
         if (ground_inliers <= THRESH_W'(GROUND_MIN)) begin
            rep.level = LVL_NO_GROUND;
         end else if (obstacle_cnt >= obs_high) begin
            rep.level = LVL_CLOSE_OBST;
         end else if (obstacle_cnt >= obs_low) begin
            rep.level = LVL_POSSIBLE_OBST;
         end else if (hole_cnt >= TOTAL_W'(HOLE_HIGH)) begin
            rep.level = LVL_CLOSE_HOLE;
         end else if (hole_cnt > TOTAL_W'(HOLE_LOW)) begin
            rep.level = LVL_POSSIBLE_HOLE;
         end else begin
            rep.level = LVL_SAFE;
         end
         rep.obstacles = obstacle_cnt;
         rep.holes = hole_cnt;
         pending_reports.insert(pending_reports.size(), rep);
         obstacle_cnt = '0;
         hole_cnt = '0;
      end
   endtask

   task automatic check_report(input logic [RSP_DATA_W-1:0] beat);
      hazard_report_type want;
      if (pending_reports.size() == 0) begin
         report_mismatch("result beat with no report outstanding", longint'(beat), 0);
      end else begin
         want = pending_reports.pop_front();
         if (beat[2:0] != want.level) begin
            report_mismatch("hazard_level", longint'(beat[2:0]), longint'(want.level));
         end
         if (beat[22:3] != want.obstacles) begin
            report_mismatch("obstacle_total", longint'(beat[22:3]),
                            longint'(want.obstacles));
         end
         if (beat[42:23] != want.holes) begin
            report_mismatch("hole_total", longint'(beat[42:23]), longint'(want.holes));
         end
         if (beat[47:43] != '0) begin
            report_mismatch("padding bits", longint'(beat[47:43]), 0);
         end
         level_mask[want.level] = 1'b1;
      end
      report_total++;
   endtask

   initial begin
      mismatches = 0;
      point_total = 0;
      report_total = 0;
      level_mask = '0;
      fail_count = 0;
      expected_left = 0;
      points_seen = 0;
      reports_seen = 0;
      levels_seen = '0;
   end

   always @(posedge clock) begin
      if (reset) begin
         plane_a = '0;
         plane_b = '0;
         plane_c = COEF_W'(RST_PLANE_C);
         plane_d = '0;
         vertical = 1'b0;
         obs_low = THRESH_W'(RST_OBS_LOW);
         obs_high = THRESH_W'(RST_OBS_HIGH);
         ground_inliers = '0;
         obstacle_cnt = '0;
         hole_cnt = '0;
         pending_reports.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            check_report(rsp_tdata);
         end
         if (csr_we) begin
            store_reg(csr_index, csr_wdata);
         end
         if (req_tvalid && req_tready) begin
            tally_point(req_tdata, req_tlast);
            point_total++;
         end
      end
      fail_count <= mismatches;
      expected_left <= pending_reports.size();
      points_seen <= point_total;
      reports_seen <= report_total;
      levels_seen <= level_mask;
   end

endmodule

/* tb/tb_point_cloud_hazard_classifier.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Point cloud hazard classifier testbench
// Drives depth points through the classifier under a series of ground plane
// settings: a directed set around the window, plane and radius boundaries,
// and randomized frames, most with random sender gaps and receiver stalls.
// The checker instance predicts and compares every report; this module makes
// stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module tb_point_cloud_hazard_classifier;
   import pchc_pkg::*;

   typedef struct {
      logic signed [COEF_W-1:0]   a, b, c;
      logic signed [OFFSET_W-1:0] d;
      logic                       vert;
      logic [THRESH_W-1:0]        lo, hi, inl;
   } plane_setup_type;

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [47:0]            req_tdata;
   logic                   req_tlast;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   int         fail_count;
   int         expected_left;
   int         points_seen;
   int         reports_seen;
   logic [7:0] levels_seen;

   bit src_idle_en;
   bit sink_idle_en;

   point_cloud_hazard_classifier u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   hazard_report_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tlast     (req_tlast),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .fail_count    (fail_count),
      .expected_left (expected_left),
      .points_seen   (points_seen),
      .reports_seen  (reports_seen),
      .levels_seen   (levels_seen)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #2000000;
      $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      int stall;
      stall = 0;
      rsp_tready <= 1'b1;
      forever begin
         @(negedge clock);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            stall--;
         end else if (sink_idle_en && $urandom_range(0, 3) == 0) begin
            stall = int'($urandom_range(1, 18)) - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   function automatic plane_setup_type make_setup(input longint a, b, c, d, input bit vert,
                                                  input int lo, hi, inl);
      plane_setup_type s;
      s.a = COEF_W'(a);
      s.b = COEF_W'(b);
      s.c = COEF_W'(c);
      s.d = OFFSET_W'(d);
      s.vert = vert;
      s.lo = THRESH_W'(lo);
      s.hi = THRESH_W'(hi);
      s.inl = THRESH_W'(inl);
      return s;
   endfunction

   function automatic int span_value(input int span);
      return int'($urandom_range(0, 2 * span)) - span;
   endfunction

   function automatic longint edge_coef();
      case ($urandom_range(0, 4))
         0: return -8388608;
         1: return 8388607;
         2: return 0;
         3: return -1;
         default: return 1;
      endcase
   endfunction

   function automatic plane_setup_type random_setup();
      plane_setup_type s;
      logic [63:0]     wide;
      wide = {$urandom, $urandom};
      case ($urandom_range(0, 4))
         0: begin
            s.a = COEF_W'(span_value(4));
            s.b = COEF_W'(span_value(4));
            s.c = COEF_W'(span_value(4));
            s.d = OFFSET_W'(span_value(1500));
         end
         1: begin
            s.a = COEF_W'(span_value(1000));
            s.b = COEF_W'(span_value(1000));
            s.c = COEF_W'(span_value(1000));
            s.d = OFFSET_W'(span_value(500000));
         end
         2: begin
            s.a = COEF_W'($urandom);
            s.b = COEF_W'($urandom);
            s.c = COEF_W'($urandom);
            s.d = wide[47:0];
         end
         3: begin
            s.a = '0;
            s.b = '0;
            s.c = '0;
            case ($urandom_range(0, 2))
               0: s.a = $urandom_range(0, 1) ? COEF_W'(1) : COEF_W'(-1);
               1: s.b = $urandom_range(0, 1) ? COEF_W'(1) : COEF_W'(-1);
               default: s.c = $urandom_range(0, 1) ? COEF_W'(1) : COEF_W'(-1);
            endcase
            s.d = OFFSET_W'(span_value(300));
         end
         default: begin
            s.a = COEF_W'(edge_coef());
            s.b = COEF_W'(edge_coef());
            s.c = COEF_W'(edge_coef());
            s.d = $urandom_range(0, 1) ? OFFSET_W'(-64'sd140737488355328)
                                       : OFFSET_W'(64'sd140737488355327);
         end
      endcase
      s.vert = 1'($urandom_range(0, 1));
      if ($urandom_range(0, 5) == 0) begin
         s.lo = THRESH_W'($urandom);
         s.hi = THRESH_W'($urandom);
      end else begin
         s.lo = THRESH_W'($urandom_range(0, 5));
         s.hi = THRESH_W'($urandom_range(0, 8));
      end
      case ($urandom_range(0, 3))
         0: s.inl = THRESH_W'($urandom);
         1: s.inl = THRESH_W'(GROUND_MIN);
         2: s.inl = THRESH_W'(GROUND_MIN + 1);
         default: s.inl = '1;
      endcase
      return s;
   endfunction

   function automatic logic signed [15:0] pick_coord(input int span);
      if ($urandom_range(0, 9) == 0) begin
         return 16'($urandom);
      end
      return 16'(span_value(span));
   endfunction

   task automatic csr_put(input logic [CSR_INDEX_W-1:0] idx, input logic [CSR_DATA_W-1:0] value);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
   endtask

   task automatic program_setup(input plane_setup_type s);
      logic [63:0] junk;
      junk = {$urandom, $urandom};
      csr_put(REG_PLANE_A, {junk[47:24], s.a});
      csr_put(REG_PLANE_B, {junk[23:0], s.b});
      csr_put(REG_PLANE_C, {junk[63:40], s.c});
      csr_put(REG_PLANE_D, s.d);
      csr_put(REG_VERTICAL, {junk[47:1], s.vert});
      csr_put(REG_OBS_LOW, {junk[27:0], s.lo});
      csr_put(REG_OBS_HIGH, {junk[55:28], s.hi});
      csr_put(REG_GROUND_INL, {junk[63:36], s.inl});
      csr_we <= 1'b0;
   endtask

   task automatic push_point(input logic signed [15:0] px, py, pz, input logic last);
      int gap;
      if (src_idle_en && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 18);
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {pz, py, px};
      req_tlast <= last;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   task automatic settle();
      req_tvalid <= 1'b0;
      while (expected_left != 0) @(posedge clock);
      repeat (40) @(negedge clock);
   endtask

   initial begin
      int phase;
      int done;
      int budget;
      int len;
      int k;
      int pause_at;
      bit paused;

      reset <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata <= '0;
      req_tlast <= 1'b0;
      csr_we <= 1'b0;
      csr_index <= REG_PLANE_A;
      csr_wdata <= '0;
      src_idle_en = 1'b1;
      sink_idle_en <= 1'b1;
      repeat (8) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Register values straight out of reset.
      push_point(0, 0, 100, 1'b0);
      push_point(-32768, -32768, -32768, 1'b0);
      push_point(32767, 32767, 32767, 1'b1);
      settle();

      // Inlier count on the no-ground boundary, plane margin boundary.
      program_setup(make_setup(0, 0, 1, 0, 1'b0, 2, 4, GROUND_MIN));
      push_point(0, 0, 60, 1'b0);
      push_point(0, 0, 61, 1'b1);
      settle();

      // Horizontal window edges, near radius and hole height edges.
      program_setup(make_setup(0, 0, 1, 0, 1'b0, 2, 4, GROUND_MIN + 1));
      push_point(-300, 0, 100, 1'b0);
      push_point(-301, 0, 100, 1'b0);
      push_point(300, 0, 100, 1'b0);
      push_point(301, 0, 100, 1'b0);
      push_point(0, 0, 500, 1'b0);
      push_point(0, 0, 501, 1'b1);
      push_point(0, 700, 240, 1'b0);
      push_point(0, 700, 239, 1'b0);
      push_point(0, 1500, 100, 1'b0);
      push_point(0, 1499, 100, 1'b0);
      push_point(0, -32768, -32768, 1'b0);
      push_point(0, 32767, -100, 1'b0);
      push_point(0, 0, -61, 1'b1);
      push_point(0, 0, 0, 1'b1);
      settle();

      // Vertical mounting with a positive x coefficient flips the plane.
      program_setup(make_setup(1, 0, 0, 0, 1'b1, 1, 1048575, 1048575));
      push_point(-500, 0, 0, 1'b0);
      push_point(-501, 0, 0, 1'b0);
      push_point(100, 0, 300, 1'b0);
      push_point(100, 0, 301, 1'b0);
      push_point(100, 0, -300, 1'b0);
      push_point(100, 0, -301, 1'b1);
      settle();

      // Degenerate plane with nonzero offset, thresholds out of order.
      program_setup(make_setup(0, 0, 0, -1, 1'b0, 1048575, 0, 1048575));
      push_point(0, 0, 0, 1'b0);
      push_point(32767, 0, 0, 1'b1);
      settle();

      program_setup(make_setup(-8388608, 8388607, -8388608, -64'sd140737488355328,
                               1'b0, 1048575, 1048575, 1048575));
      push_point(-300, -32768, -32768, 1'b0);
      push_point(300, 32767, 500, 1'b0);
      push_point(0, 0, 0, 1'b1);
      settle();

      for (phase = 0; phase < 10; phase++) begin
         if (phase == 8) begin
            src_idle_en = 1'b0;
            sink_idle_en <= 1'b0;
         end
         program_setup(random_setup());
         done = 0;
         budget = 48;
         pause_at = $urandom_range(10, 40);
         paused = 1'b0;
         while (done < budget) begin
            len = $urandom_range(1, 12);
            for (k = 0; k < len; k++) begin
               if ($urandom_range(0, 9) == 0) begin
                  push_point(16'($urandom), 16'($urandom), 16'($urandom), k == len - 1);
               end else if ($urandom_range(0, 7) == 0) begin
                  push_point(pick_coord(520), 16'($urandom), pick_coord(620), k == len - 1);
               end else begin
                  push_point(pick_coord(520), pick_coord(2000), pick_coord(620), k == len - 1);
               end
            end
            done += len;
            if (!paused && done >= pause_at) begin
               settle();
               paused = 1'b1;
            end
         end
         settle();
      end

      req_tvalid <= 1'b0;
      while (expected_left != 0) @(posedge clock);
      repeat (50) @(posedge clock);

      $display("Run covered %0d points and %0d frame reports under 16 plane settings.",
               points_seen, reports_seen);
      $display("Hazard levels reported (bit per level): %b", levels_seen);
      if (fail_count == 0 && expected_left == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
